// ----- rtl/median_filter_3x3_defines.svh -----
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// Shared property forms for the checker; clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// same-cycle implication
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, constants and compare helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

	localparam int PIX_W         = 8;
	localparam int CFG_W         = 12;
	localparam int ROW_W         = 12;
	localparam int MAX_WIDTH_DEF = 2048;
	localparam int FW_RESET      = 640;
	localparam int FH_RESET      = 480;
	localparam int MIN_DIM       = 3;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             frame_start;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] median_out;
		logic             out_valid;
		logic             frame_end;
	} result_t;

	function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] c);
		return min2(min2(a, b), c);
	endfunction

	function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] c);
		return max2(max2(a, b), c);
	endfunction

	function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
			input logic [PIX_W-1:0] c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

endpackage

// ----- rtl/median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median on 8-bit grey pixels with two line stores kept in
// one dual-port memory and a pipelined column-sort median network.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------
//  pixel   | pixel_valid / pixel_ready  | pixel  (pixel_in, frame_start)
//  result  | result_valid / result_ready| result (median_out, out_valid,
//          |                            |         frame_end)
//  config  | cfg_we                     | cfg_index, cfg_data
//
// One pixel per clock unless result_ready stalls it; results pass stage 1 to stage 4,
// then the output register. The line memory is read when a pixel is taken and
// written as it leaves stage 1, with forwarding when the next pixel hits the same column.
// Reset clears position, window and pipeline valids; the line memory is not cleared.
// A stalled result holds every stage behind it; empty stages still fill.
// ----------------------------------------------------------------------------
module median_filter_3x3
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  pixel_t           pixel,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > CFG_W) ? WW : CFG_W;
	localparam int LW = 2 * PIX_W;

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [EW-1:0]    fw_ext, w_eff, col_nx;
	logic [CFG_W-1:0] h_eff;
	logic [CW-1:0]    col_base, col_cur;
	logic [ROW_W-1:0] row_base, row_inc, row_cur, row_nx;
	logic             col_wrap, accept, wr_en;

	logic en_s1, en_s2, en_s3, en_s4, en_out;

	logic [LW-1:0] line_mem [MAX_WIDTH];

	logic             v_s1, fwd_s1, valid_s1, med_en_s1, last_s1;
	logic [LW-1:0]    rd_s1, fwd_data_s1;
	logic [PIX_W-1:0] px_s1, top_s1, mid_s1;
	logic [CW-1:0]    col_s1;

	logic [5:0][PIX_W-1:0] window_cols_q;

	logic                  v_s2, valid_s2, med_en_s2, last_s2;
	logic [8:0][PIX_W-1:0] win_s2;

	logic                  v_s3, valid_s3, med_en_s3, last_s3;
	logic [2:0][PIX_W-1:0] lo_s3, md_s3, hi_s3;

	logic             v_s4, valid_s4, med_en_s4, last_s4;
	logic [PIX_W-1:0] a_s4, b_s4, c_s4;

	logic    res_v_q;
	result_t res_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W'(FW_RESET);
			frame_height_q <= CFG_W'(FH_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
			endcase
		end
	end

	// stall chain
	assign en_out      = !res_v_q || result_ready;
	assign en_s4       = !v_s4 || en_out;
	assign en_s3       = !v_s3 || en_s4;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign pixel_ready = en_s1;
	assign accept      = pixel_valid && en_s1;
	assign wr_en       = v_s1 && en_s2;

	// position
	always_comb begin
		fw_ext = EW'(frame_width_q);
		if (fw_ext < EW'(MIN_DIM))
			w_eff = EW'(MIN_DIM);
		else if (fw_ext > EW'(MAX_WIDTH))
			w_eff = EW'(MAX_WIDTH);
		else
			w_eff = fw_ext;
		h_eff    = (frame_height_q < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : frame_height_q;
		col_base = pixel.frame_start ? '0 : col_q;
		row_base = pixel.frame_start ? '0 : row_q;
		col_wrap = EW'(col_base) >= w_eff;
		col_cur  = col_wrap ? '0 : col_base;
		row_inc  = col_wrap ? row_base + ROW_W'(1) : row_base;
		row_cur  = (row_inc >= ROW_W'(h_eff)) ? '0 : row_inc;
		col_nx   = EW'(col_cur) + EW'(1);
		row_nx   = row_cur + ROW_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_nx >= w_eff) begin
				col_q <= '0;
				row_q <= (row_nx >= ROW_W'(h_eff)) ? '0 : row_nx;
			end else begin
				col_q <= col_nx[CW-1:0];
				row_q <= row_cur;
			end
		end
	end

	// line memory: {older, newer} per column
	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem[col_s1] <= {mid_s1, px_s1};
		if (en_s1)
			rd_s1 <= line_mem[col_cur];
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1       <= pixel.pixel_in;
			col_s1      <= col_cur;
			valid_s1    <= (row_cur >= ROW_W'(1)) && (col_cur >= CW'(1));
			med_en_s1   <= (row_cur >= ROW_W'(2)) && (EW'(col_cur) >= EW'(2));
			last_s1     <= (row_cur == ROW_W'(h_eff - CFG_W'(1)))
			               && (EW'(col_cur) == w_eff - EW'(1));
			fwd_s1      <= wr_en && (col_s1 == col_cur);
			fwd_data_s1 <= {mid_s1, px_s1};
		end
	end

	assign top_s1 = fwd_s1 ? fwd_data_s1[LW-1:PIX_W] : rd_s1[LW-1:PIX_W];
	assign mid_s1 = fwd_s1 ? fwd_data_s1[PIX_W-1:0]  : rd_s1[PIX_W-1:0];

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_cols_q <= '0;
		else if (wr_en)
			window_cols_q <= {px_s1, mid_s1, top_s1, window_cols_q[5:3]};
	end

	// stage 2: full window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			win_s2    <= {px_s1, mid_s1, top_s1, window_cols_q};
			valid_s2  <= valid_s1;
			med_en_s2 <= med_en_s1;
			last_s2   <= last_s1;
		end
	end

	// stage 3: sort each column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en_s3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < 3; k++) begin
				lo_s3[k] <= min3(win_s2[3*k], win_s2[3*k+1], win_s2[3*k+2]);
				md_s3[k] <= med3(win_s2[3*k], win_s2[3*k+1], win_s2[3*k+2]);
				hi_s3[k] <= max3(win_s2[3*k], win_s2[3*k+1], win_s2[3*k+2]);
			end
			valid_s3  <= valid_s2;
			med_en_s3 <= med_en_s2;
			last_s3   <= last_s2;
		end
	end

	// stage 4: max of lows, median of mids, min of highs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en_s4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			a_s4      <= max3(lo_s3[0], lo_s3[1], lo_s3[2]);
			b_s4      <= med3(md_s3[0], md_s3[1], md_s3[2]);
			c_s4      <= min3(hi_s3[0], hi_s3[1], hi_s3[2]);
			valid_s4  <= valid_s3;
			med_en_s4 <= med_en_s3;
			last_s4   <= last_s3;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else if (en_out)
			res_v_q <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q.median_out <= med_en_s4 ? med3(a_s4, b_s4, c_s4) : '0;
			res_q.out_valid  <= valid_s4;
			res_q.frame_end  <= last_s4;
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule

// ----- rtl/mf3_checker.sv -----
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks for median_filter_3x3, attached by bind.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_defines.svh"

module mf3_checker
	import mf3_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    pixel_valid,
	input logic    pixel_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic [3:0] pending_q;
	logic       in_xact, out_xact;

	assign in_xact  = pixel_valid && pixel_ready;
	assign out_xact = result_valid && result_ready;

	// transactions taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (in_xact && !out_xact)
			pending_q <= pending_q + 4'd1;
		else if (out_xact && !in_xact)
			pending_q <= pending_q - 4'd1;
	end

	`MF3_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
	`MF3_ASSERT_NOW(a_no_phantom, result_valid, pending_q != 4'd0, "result without a pending transaction")
	`MF3_ASSERT_NOW(a_invalid_zero, result_valid && !result.out_valid, result.median_out == '0, "nonzero median on invalid centre")
	`MF3_ASSERT_NOW(a_end_valid, result_valid && result.frame_end, result.out_valid, "frame end on invalid centre")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);

// ----- tb/tb_median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// tb_median_filter_3x3
// Streams raster pixels through the 3x3 median filter under random flow
// control and checks every result against an in-bench model of the line
// stores, window and frame position. It covers geometry changes (saturated,
// shrunk mid frame), mid-frame frame starts, output back-pressure and a long
// run at the widest supported row.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3;
	timeunit 1ns;
	timeprecision 1ps;

	import mf3_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int WIDE_ITEMS   = 320;

	class median_scoreboard;
		logic [CFG_W-1:0] width_reg  = CFG_W'(FW_RESET);
		logic [CFG_W-1:0] height_reg = CFG_W'(FH_RESET);
		bit [PIX_W-1:0] line_up2 [MAX_WIDTH_DEF];
		bit [PIX_W-1:0] line_up1 [MAX_WIDTH_DEF];
		bit [PIX_W-1:0] prev_cols [6];
		int unsigned next_row = 0;
		int unsigned next_col = 0;
		result_t expected_results [$];
		int errors = 0;

		function int unsigned eff_width();
			if (width_reg < MIN_DIM) return MIN_DIM;
			if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return 32'(width_reg);
		endfunction

		function int unsigned eff_height();
			if (height_reg < MIN_DIM) return MIN_DIM;
			return 32'(height_reg);
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				CFG_FRAME_WIDTH: width_reg = val;
				CFG_FRAME_HEIGHT: height_reg = val;
				default: ;
			endcase
		endfunction

		function logic [PIX_W-1:0] window_median(bit [PIX_W-1:0] win [9]);
			bit [PIX_W-1:0] s [9];
			bit [PIX_W-1:0] tmp;
			int k;
			s = win;
			for (int i = 0; i < 5; i++) begin
				k = i;
				for (int j = i + 1; j < 9; j++)
					if (s[j] < s[k]) k = j;
				tmp = s[i];
				s[i] = s[k];
				s[k] = tmp;
			end
			return s[4];
		endfunction

		function void take_pixel(pixel_t p);
			int unsigned w, h, row, col;
			bit [PIX_W-1:0] top, mid;
			bit [PIX_W-1:0] win [9];
			result_t r;
			w = eff_width();
			h = eff_height();
			if (p.frame_start) begin
				next_row = 0;
				next_col = 0;
			end
			if (next_col >= w) begin
				next_col = 0;
				next_row++;
			end
			if (next_row >= h) next_row = 0;
			row = next_row;
			col = next_col;
			top = line_up2[col];
			mid = line_up1[col];
			line_up2[col] = mid;
			line_up1[col] = p.pixel_in;
			for (int i = 0; i < 6; i++) win[i] = prev_cols[i];
			win[6] = top;
			win[7] = mid;
			win[8] = p.pixel_in;
			r.median_out = (row >= 2 && col >= 2) ? window_median(win) : '0;
			r.out_valid = (row >= 1 && col >= 1);
			r.frame_end = (row == h - 1 && col == w - 1);
			for (int i = 0; i < 3; i++) prev_cols[i] = prev_cols[i + 3];
			prev_cols[3] = top;
			prev_cols[4] = mid;
			prev_cols[5] = p.pixel_in;
			next_col = col + 1;
			if (next_col >= w) begin
				next_col = 0;
				next_row = row + 1;
				if (next_row >= h) next_row = 0;
			end
			expected_results.push_back(r);
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual median=%0d valid=%0b end=%0b",
					$time, got.median_out, got.out_valid, got.frame_end);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.median_out !== want.median_out) begin
				$display("%0t: median_out expected %0d actual %0d",
					$time, want.median_out, got.median_out);
				errors++;
			end
			if (got.out_valid !== want.out_valid) begin
				$display("%0t: out_valid expected %0b actual %0b",
					$time, want.out_valid, got.out_valid);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$display("%0t: frame_end expected %0b actual %0b",
					$time, want.frame_end, got.frame_end);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic pixel_valid;
	logic pixel_ready;
	pixel_t pixel;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	median_scoreboard sb = new();
	int tx_idle_pct = 26;
	int rx_idle_pct = 26;
	int rx_hold_cycles = 0;
	int rand_items = 0;
	int stall_cycles = 0;
	bit force_start = 0;

	median_filter_3x3 dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result side: random ready, plus long holds on request
	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) sb.match_result(result);
			if (rx_hold_cycles > 0) begin
				result_ready <= 1'b0;
				rx_hold_cycles--;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic send_pixel(logic [PIX_W-1:0] val, bit fs);
		pixel_t p;
		p.pixel_in = val;
		p.frame_start = fs | force_start;
		if (p.frame_start) force_start = 0;
		while ($urandom_range(99) < tx_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!pixel_ready);
		sb.take_pixel(p);
	endtask

	task automatic drain_results();
		pixel_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// a wider row reads line entries never written in this frame: restart it
	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		int unsigned old_w;
		old_w = sb.eff_width();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sb.eff_width() > old_w) force_start = 1;
	endtask

	task automatic run_random_phase();
		logic [CFG_W-1:0] w_val, h_val;
		int unsigned frames, rows, n, mode, base;
		bit carry_on;
		logic [PIX_W-1:0] v;
		case ($urandom_range(7))
			0: w_val = CFG_W'($urandom_range(2));
			default: w_val = CFG_W'($urandom_range(24, 3));
		endcase
		case ($urandom_range(7))
			0: h_val = CFG_W'($urandom_range(2));
			1: h_val = '1;
			default: h_val = CFG_W'($urandom_range(10, 3));
		endcase
		drain_results();
		write_reg(CFG_FRAME_WIDTH, w_val);
		write_reg(CFG_FRAME_HEIGHT, h_val);
		frames = $urandom_range(3, 1);
		carry_on = ($urandom_range(3) == 0);
		for (int f = 0; f < frames; f++) begin
			rows = (sb.eff_height() > 8) ? 8 : sb.eff_height();
			n = sb.eff_width() * rows;
			if ($urandom_range(5) == 0) n = $urandom_range(n, 1);
			mode = $urandom_range(2);
			base = $urandom_range(252);
			for (int i = 0; i < n; i++) begin
				case (mode)
					0: v = PIX_W'($urandom_range(255));
					1: v = $urandom_range(1) ? 8'hFF : 8'h00;
					default: v = PIX_W'(base + $urandom_range(3));
				endcase
				send_pixel(v, (i == 0 && !(f == 0 && carry_on)) || ($urandom_range(49) == 0));
				rand_items++;
			end
		end
	endtask

	initial begin
		logic [PIX_W-1:0] frame_vals [6];
		arst_n = 1'b0;
		pixel_valid <= 1'b0;
		pixel <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: first row only, position starts at zero
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'h55, 1'b0);
		send_pixel(8'h0F, 1'b0);
		drain_results();

		// undersized values saturate to 3x3; column 5 now wraps to the next row
		write_reg(CFG_FRAME_WIDTH, '0);
		write_reg(CFG_FRAME_HEIGHT, '0);
		frame_vals = '{8'h80, 8'h01, 8'hFE, 8'h7F, 8'h00, 8'hFF};
		foreach (frame_vals[i]) send_pixel(frame_vals[i], 1'b0);
		for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
		send_pixel(8'h10, 1'b0);
		send_pixel(8'h20, 1'b1);
		send_pixel(8'h30, 1'b0);

		// back-pressure: output held off while input keeps coming
		drain_results();
		write_reg(CFG_FRAME_WIDTH, 12'd16);
		write_reg(CFG_FRAME_HEIGHT, 12'd8);
		tx_idle_pct = 0;
		rx_hold_cycles = 300;
		for (int i = 0; i < 128; i++) send_pixel(PIX_W'($urandom_range(255)), i == 0);
		tx_idle_pct = 26;
		drain_results();

		// widest row, no idling on either side
		write_reg(CFG_FRAME_WIDTH, '1);
		write_reg(CFG_FRAME_HEIGHT, 12'd3);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(PIX_W'($urandom_range(255)), i == 0);
		tx_idle_pct = 26;
		rx_idle_pct = 26;

		while (rand_items < RANDOM_ITEMS) run_random_phase();

		pixel_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ----- median_filter_3x3.f -----
+incdir+rtl
rtl/mf3_pkg.sv
rtl/median_filter_3x3.sv
rtl/mf3_checker.sv
tb/tb_median_filter_3x3.sv
